@@ sv/ppc_pkg.sv @@
// Shared types and constants for the pinhole camera projection pipeline.
`default_nettype none
package ppc_pkg;

  // Quotient bits produced by the divider; larger quotients are flagged as overflow.
  localparam int QUO_W = 42;
  localparam int DIV_W = 32;
  // Input capture, operand, product and magnitude stages, then the divider, then two finishing stages.
  localparam int NUM_STAGES = 4 + QUO_W + 2;

  // Operation codes.
  localparam logic OP_PROJECT   = 1'b0;
  localparam logic OP_UNPROJECT = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_FOCAL_X  = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] REG_CENTER_X = 3'd2;
  localparam logic [2:0] REG_CENTER_Y = 3'd3;
  localparam logic [2:0] REG_WIDTH    = 3'd4;
  localparam logic [2:0] REG_HEIGHT   = 3'd5;

  // One division lane: partial remainder, shifting dividend/quotient word, divisor, sign and overflow flags.
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [DIV_W-1:0] div;
    logic             neg;
    logic             big;
  } ppc_lane_t;

  // Per-word side information that rides alongside the divider.
  typedef struct packed {
    logic        op;
    logic        pre_ok;
    logic        in_pix;
    logic [31:0] depth;
  } ppc_side_t;

endpackage
`default_nettype wire

@@ sv/ppc_div_stage.sv @@
// One registered restoring-division step producing a single quotient bit.
`default_nettype none
module ppc_div_stage (
  input  wire                clk_i,
  input  wire                en_i,
  input  ppc_pkg::ppc_lane_t lane_i,
  output ppc_pkg::ppc_lane_t lane_o
);
  import ppc_pkg::*;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;
  ppc_lane_t      lane_d;
  ppc_lane_t      lane_q;

  // Shift the next dividend bit into the remainder and try a subtraction.
  always_comb begin
    trial  = {lane_i.rem, lane_i.quo[QUO_W-1]};
    diff   = trial - {1'b0, lane_i.div};
    ge     = (trial >= {1'b0, lane_i.div});
    lane_d = lane_i;
    lane_d.rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    lane_d.quo = {lane_i.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule
`default_nettype wire

@@ sv/pinhole_camera_projection_top.sv @@
// Each word goes through the capture, operand, product, magnitude, divider and finishing stages.
// Throughput: one word per cycle unless stalled; the divider is a 42-stage restoring pipeline, one bit a stage.
// A stall holds only the full stages behind the stalled output; empty stages keep filling.
// Reset clears all valid bits and loads the default camera intrinsics; data registers are not reset.
`default_nettype none
module pinhole_camera_projection_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         op_i,
  input  wire  [31:0] point_x_i,
  input  wire  [31:0] point_y_i,
  input  wire  [31:0] point_z_i,
  input  wire  [31:0] pixel_u_i,
  input  wire  [31:0] pixel_v_i,
  input  wire  [31:0] depth_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic        ok_o,
  output logic [31:0] out_u_o,
  output logic [31:0] out_v_o,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic        inside_image_o,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i
);
  import ppc_pkg::*;

  localparam int NS = NUM_STAGES;
  localparam int SW = 44;
  localparam logic [NS-1:0] ONE_NS = NS'(1);

  // Configuration registers.
  logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [15:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= 32'd32768000;
      focal_y_q  <= 32'd32768000;
      center_x_q <= 32'd20971520;
      center_y_q <= 32'd15728640;
      width_q    <= 16'd640;
      height_q   <= 16'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FOCAL_X:  focal_x_q  <= cfg_data_i;
        REG_FOCAL_Y:  focal_y_q  <= cfg_data_i;
        REG_CENTER_X: center_x_q <= cfg_data_i;
        REG_CENTER_Y: center_y_q <= cfg_data_i;
        REG_WIDTH:    width_q    <= cfg_data_i[15:0];
        REG_HEIGHT:   height_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Pixel inside test at full precision.
  function automatic logic pix_in(input logic [SW-1:0] u, input logic [SW-1:0] v,
                                  input logic [15:0] w, input logic [15:0] h);
    logic [SW-1:0] lim_w;
    logic [SW-1:0] lim_h;
    lim_w = SW'(w) << FRAC_BITS;
    lim_h = SW'(h) << FRAC_BITS;
    return !u[SW-1] && !v[SW-1] && (u < lim_w) && (v < lim_h);
  endfunction

  // Valid bits and stage enables: a stage moves when the output is ready or any stage from it onwards is empty.
  logic [NS-1:0] valid_q;
  logic [NS-1:0] valid_in;
  logic [NS-1:0] en;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = out_ready_i || ((valid_q | ((ONE_NS << k) - ONE_NS)) != '1);
    end
  end

  // Each stage takes the valid bit of the stage in front of it.
  assign valid_in = {valid_q[NS-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_in[k];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NS-1];

  // Stage 0: capture the input word.
  logic        op_q;
  logic [31:0] px_q, py_q, pz_q, pu_q, pv_q, dp_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      op_q <= op_i;
      px_q <= point_x_i;
      py_q <= point_y_i;
      pz_q <= point_z_i;
      pu_q <= pixel_u_i;
      pv_q <= pixel_v_i;
      dp_q <= depth_i;
    end
  end

  // Stage 1: multiplier operands, divisors and early checks.
  logic signed [32:0] a_u_d, b_u_d, a_v_d, b_v_d;
  logic signed [32:0] a_u_q, b_u_q, a_v_q, b_v_q;
  logic [31:0]        dv_u_d, dv_v_d, dv_u_q, dv_v_q;
  ppc_side_t          side1_d, side1_q;

  always_comb begin
    side1_d.op    = op_q;
    side1_d.depth = dp_q;
    side1_d.in_pix = pix_in(SW'($signed(pu_q)), SW'($signed(pv_q)), width_q, height_q);
    if (op_q == OP_PROJECT) begin
      a_u_d  = $signed({1'b0, focal_x_q});
      b_u_d  = 33'($signed(px_q));
      a_v_d  = $signed({1'b0, focal_y_q});
      b_v_d  = 33'($signed(py_q));
      side1_d.pre_ok = !pz_q[31] && (pz_q != '0);
      dv_u_d = pz_q;
      dv_v_d = pz_q;
    end else begin
      a_u_d  = 33'($signed(pu_q)) - 33'($signed(center_x_q));
      b_u_d  = 33'($signed(dp_q));
      a_v_d  = 33'($signed(pv_q)) - 33'($signed(center_y_q));
      b_v_d  = 33'($signed(dp_q));
      side1_d.pre_ok = !dp_q[31] && (dp_q != '0) && (focal_x_q != '0) && (focal_y_q != '0);
      dv_u_d = focal_x_q;
      dv_v_d = focal_y_q;
    end
    // A divisor that cannot be used is replaced by one; the result is discarded anyway.
    if (!side1_d.pre_ok) begin
      dv_u_d = 32'd1;
      dv_v_d = 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      a_u_q   <= a_u_d;
      b_u_q   <= b_u_d;
      a_v_q   <= a_v_d;
      b_v_q   <= b_v_d;
      dv_u_q  <= dv_u_d;
      dv_v_q  <= dv_v_d;
      side1_q <= side1_d;
    end
  end

  // Stage 2: full-width signed products.
  logic signed [65:0] prod_u_q, prod_v_q;
  logic [31:0]        dv_u2_q, dv_v2_q;
  ppc_side_t          side2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      prod_u_q <= a_u_q * b_u_q;
      prod_v_q <= a_v_q * b_v_q;
      dv_u2_q  <= dv_u_q;
      dv_v2_q  <= dv_v_q;
      side2_q  <= side1_q;
    end
  end

  // Stage 3: magnitudes, quotient range check and divider set-up.
  function automatic ppc_lane_t lane_init(input logic [65:0] prod, input logic [31:0] dv);
    logic [65:0] mag;
    ppc_lane_t   ln;
    mag    = prod[65] ? (66'd0 - prod) : prod;
    ln.neg = prod[65];
    ln.div = dv;
    ln.rem = DIV_W'(mag[63:QUO_W]);
    ln.quo = mag[QUO_W-1:0];
    ln.big = (DIV_W'(mag[63:QUO_W]) >= dv);
    return ln;
  endfunction

  ppc_lane_t lane_u [0:QUO_W];
  ppc_lane_t lane_v [0:QUO_W];
  ppc_side_t side_q [0:QUO_W];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      lane_u[0] <= lane_init(prod_u_q, dv_u2_q);
      lane_v[0] <= lane_init(prod_v_q, dv_v2_q);
      side_q[0] <= side2_q;
    end
  end

  // Divider stages: one quotient bit per stage for each axis.
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    ppc_div_stage u_stage_u (
      .clk_i  (clk_i),
      .en_i   (en[4+k]),
      .lane_i (lane_u[k]),
      .lane_o (lane_u[k+1])
    );
    ppc_div_stage u_stage_v (
      .clk_i  (clk_i),
      .en_i   (en[4+k]),
      .lane_i (lane_v[k]),
      .lane_o (lane_v[k+1])
    );
    always_ff @(posedge clk_i) begin
      if (en[4+k]) begin
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // Finishing stage 1: apply the sign and check the quotient range.
  function automatic logic quo_bad(input ppc_lane_t ln, input logic op);
    logic [QUO_W-1:0] lim_p;
    lim_p = (op == OP_PROJECT) ? (QUO_W'(1) << 40) : ((QUO_W'(1) << 31) - QUO_W'(ln.neg ? 0 : 1));
    return ln.big || (ln.quo > lim_p);
  endfunction

  localparam int QS = QUO_W + 1;
  logic signed [QS-1:0] q_u_q, q_v_q;
  logic                 ok1_q;
  ppc_side_t            side_f_q;

  always_ff @(posedge clk_i) begin
    if (en[NS-2]) begin
      q_u_q <= lane_u[QUO_W].neg ? (QS'(0) - {1'b0, lane_u[QUO_W].quo})
                                 : {1'b0, lane_u[QUO_W].quo};
      q_v_q <= lane_v[QUO_W].neg ? (QS'(0) - {1'b0, lane_v[QUO_W].quo})
                                 : {1'b0, lane_v[QUO_W].quo};
      ok1_q <= side_q[QUO_W].pre_ok && !quo_bad(lane_u[QUO_W], side_q[QUO_W].op)
               && !quo_bad(lane_v[QUO_W], side_q[QUO_W].op);
      side_f_q <= side_q[QUO_W];
    end
  end

  // Finishing stage 2: for projection add the principal point and check final overflow; inside test and zeroing.
  logic signed [SW-1:0] r_u, r_v;
  logic                 fit_u, fit_v, ok_d, in_d;
  logic [31:0]          ou_d, ov_d, ox_d, oy_d, oz_d;

  always_comb begin
    r_u   = SW'(q_u_q) + SW'($signed(center_x_q));
    r_v   = SW'(q_v_q) + SW'($signed(center_y_q));
    fit_u = (r_u >= -(SW'(1) <<< 31)) && (r_u < (SW'(1) <<< 31));
    fit_v = (r_v >= -(SW'(1) <<< 31)) && (r_v < (SW'(1) <<< 31));
    ou_d = '0;
    ov_d = '0;
    ox_d = '0;
    oy_d = '0;
    oz_d = '0;
    if (side_f_q.op == OP_PROJECT) begin
      ok_d = ok1_q && fit_u && fit_v;
      in_d = ok_d && pix_in(r_u, r_v, width_q, height_q);
      if (ok_d) begin
        ou_d = r_u[31:0];
        ov_d = r_v[31:0];
      end
    end else begin
      ok_d = ok1_q;
      in_d = side_f_q.in_pix;
      if (ok_d) begin
        ox_d = q_u_q[31:0];
        oy_d = q_v_q[31:0];
        oz_d = side_f_q.depth;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      ok_o           <= ok_d;
      out_u_o        <= ou_d;
      out_v_o        <= ov_d;
      out_x_o        <= ox_d;
      out_y_o        <= oy_d;
      out_z_o        <= oz_d;
      inside_image_o <= in_d;
    end
  end

  // Checks on the pipeline control and result formatting.
  a_ready_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the output is free");

  a_not_ok_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (out_u_o == '0 && out_v_o == '0 && out_x_o == '0
                                && out_y_o == '0 && out_z_o == '0))
    else $error("failed result carries non-zero values");

  a_depth_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ok_o) |-> !out_z_o[31])
    else $error("accepted result with negative depth");

endmodule
`default_nettype wire
